>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, reset included
`define LJ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// check on every rising edge outside reset
`define LJ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> rtl/core/ljwca_pkg.sv
`timescale 1ns / 1ps
package ljwca_pkg;

  localparam int DIST_W    = 24;
  localparam int OUT_W     = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WELL_DEPTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POTENTIAL_MODE = 2'd2;

  localparam logic [DIST_W-1:0] WELL_DEPTH_RST   = 24'h01_0000;
  localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 24'h01_0000;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

endpackage

>>> rtl/core/ljwca_div.sv
`timescale 1ns / 1ps
module ljwca_div
  import ljwca_pkg::*;
#(
  parameter int DW = 40,
  parameter int QW = 21,
  parameter int TW = 1
) (
  input  logic              clk,
  input  logic [DW-1:0]     dividend,
  input  logic [DIST_W-1:0] divisor,
  input  logic [TW-1:0]     tag_in,
  output logic [QW-1:0]     quot,
  output logic [TW-1:0]     tag_out
);

  logic [DIST_W-1:0] rem_r [QW-1];
  logic [DIST_W-1:0] dvs_r [QW-1];
  logic [QW-1:0]     low_r [QW];
  logic [TW-1:0]     tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DIST_W-1:0] rem_in;
    logic [DIST_W-1:0] dvs_in;
    logic [QW-1:0]     low_in;
    logic [TW-1:0]     tg_in;
    logic [DIST_W:0]   trial;
    logic [DIST_W:0]   diff;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = DIST_W'(dividend[DW-1:QW]);
      assign dvs_in = divisor;
      assign low_in = dividend[QW-1:0];
      assign tg_in  = tag_in;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign low_in = low_r[k-1];
      assign tg_in  = tag_r[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign take  = !diff[DIST_W];

    always_ff @(posedge clk) begin
      low_r[k] <= {low_in[QW-2:0], take};
      tag_r[k] <= tg_in;
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k] <= take ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
        dvs_r[k] <= dvs_in;
      end
    end
  end

  assign quot    = low_r[QW-1];
  assign tag_out = tag_r[QW-1];

endmodule

>>> rtl/core/lennard_jones_wca_pair_evaluator_unit.sv
`timescale 1ns / 1ps
// channel   ports                                          transfer
// input     start, busy, in_distance                       start high, busy low
// result    out_valid, out_energy, out_force_res, out_status  out_valid, one cycle
// config    cfg_we, cfg_index, cfg_wdata                   cfg_we high
//
// One transaction enters per cycle; busy stays low.
// An accepted transaction passes through one input stage, the 36-stage
// restoring divider for 12/r (rmin/r runs alongside in 21 stages), and ten
// multiply, subtract and clamp stages.
// Synchronous reset restores the register defaults and drops transactions in flight.
// The receiver cannot stall; results are never held.
`include "assert_macros.svh"
module lennard_jones_wca_pair_evaluator_unit
  import ljwca_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [DIST_W-1:0]       in_distance,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIST_W-1:0]       cfg_wdata,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_energy,
  output logic signed [OUT_W-1:0] out_force_res,
  output logic [1:0]              out_status
);

  localparam int QW_Q   = 21;
  localparam int QW_INV = 36;
  localparam int QD_N   = QW_INV - QW_Q;
  localparam logic [QW_INV:0] INV_NUM = 37'h0C_0000_0000;

  typedef struct packed {
    logic zero;
    logic beyond;
    logic ovf;
  } flag_t;

  logic [DIST_W-1:0] well_depth_r;
  logic [DIST_W-1:0] min_distance_r;
  logic              potential_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      well_depth_r     <= WELL_DEPTH_RST;
      min_distance_r   <= MIN_DISTANCE_RST;
      potential_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WELL_DEPTH:     well_depth_r     <= cfg_wdata;
        CFG_MIN_DISTANCE:   min_distance_r   <= cfg_wdata;
        CFG_POTENTIAL_MODE: potential_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage
  logic              s0_valid_r;
  logic [DIST_W-1:0] s0_dist_r;
  logic              s0_zero_r;
  logic              s0_beyond_r;
  logic              s0_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_dist_r   <= in_distance;
    s0_zero_r   <= (in_distance == '0);
    s0_beyond_r <= !potential_mode_r && (in_distance >= min_distance_r);
    s0_ovf_r    <= ({5'b0, min_distance_r, 16'h0} >= {in_distance, 21'h0});
  end

  // dividers
  logic [QW_Q-1:0]   dq_q;
  logic              dq_ovf;
  logic [QW_INV-1:0] dinv_q;
  logic [1:0]        dinv_tag;

  ljwca_div #(.DW(40), .QW(QW_Q), .TW(1)) u_div_q (
    .clk      (clk),
    .dividend ({min_distance_r, 16'h0}),
    .divisor  (s0_dist_r),
    .tag_in   (s0_ovf_r),
    .quot     (dq_q),
    .tag_out  (dq_ovf)
  );

  ljwca_div #(.DW(QW_INV + 1), .QW(QW_INV), .TW(2)) u_div_inv (
    .clk      (clk),
    .dividend (INV_NUM),
    .divisor  (s0_dist_r),
    .tag_in   ({s0_zero_r, s0_beyond_r}),
    .quot     (dinv_q),
    .tag_out  (dinv_tag)
  );

  logic [QW_Q:0]     qd_r [QD_N];
  logic [QW_INV-1:0] vld_r;

  always_ff @(posedge clk) begin
    qd_r[0] <= {dq_ovf, dq_q};
    for (int i = 1; i < QD_N; i++) begin
      qd_r[i] <= qd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QW_INV-2:0], s0_valid_r};
    end
  end

  logic [QW_Q-1:0] q0;
  flag_t           fl0;

  assign q0  = qd_r[QD_N-1][QW_Q-1:0];
  assign fl0 = '{zero: dinv_tag[1], beyond: dinv_tag[0], ovf: qd_r[QD_N-1][QW_Q]};

  // arithmetic stages
  logic [9:1] av_r;
  flag_t      fl_r [1:9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= '0;
    end else begin
      av_r <= {av_r[8:1], vld_r[QW_INV-1]};
    end
  end

  always_ff @(posedge clk) begin
    fl_r[1] <= fl0;
    for (int i = 2; i <= 9; i++) begin
      fl_r[i] <= fl_r[i-1];
    end
  end

  logic [41:0] q_sq;
  logic [41:0] epi_lo;
  logic [41:0] epi_hi;
  logic [20:0] a1_q_r;
  logic [25:0] a1_q2_r;
  logic [41:0] a1_pl_r;
  logic [41:0] a1_ph_r;

  assign q_sq   = 42'(q0) * 42'(q0);
  assign epi_lo = 42'(well_depth_r) * 42'(dinv_q[17:0]);
  assign epi_hi = 42'(well_depth_r) * 42'(dinv_q[35:18]);

  logic [46:0] q2q;
  logic [59:0] a_sum;
  logic [30:0] a2_q3_r;
  logic [59:0] a2_a_r;

  assign q2q   = 47'(a1_q2_r) * 47'(a1_q_r);
  assign a_sum = 60'(a1_pl_r) + {a1_ph_r, 18'b0};

  logic [61:0] q3sq;
  logic [45:0] a3_s_r;
  logic [59:0] a3_a_r;

  assign q3sq = 62'(a2_q3_r) * 62'(a2_q3_r);

  logic [45:0] pp_hh;
  logic [45:0] pp_hl;
  logic [45:0] pp_ll;
  logic [45:0] a4_hh_r;
  logic [45:0] a4_hl_r;
  logic [45:0] a4_ll_r;
  logic [45:0] a4_s_r;
  logic [59:0] a4_a_r;

  assign pp_hh = 46'(a3_s_r[45:23]) * 46'(a3_s_r[45:23]);
  assign pp_hl = 46'(a3_s_r[45:23]) * 46'(a3_s_r[22:0]);
  assign pp_ll = 46'(a3_s_r[22:0]) * 46'(a3_s_r[22:0]);

  logic [91:0] s2_full;
  logic [75:0] a5_s2_r;
  logic [45:0] a5_s_r;
  logic [59:0] a5_a_r;

  assign s2_full = {a4_hh_r, 46'b0} + 92'({a4_hl_r, 24'b0}) + 92'(a4_ll_r);

  logic [76:0] s2x;
  logic [76:0] twos;
  logic [76:0] ones;
  logic        eneg;
  logic        fneg;
  logic [76:0] ediff;
  logic [76:0] fdiff;
  logic [75:0] a6_emag_r;
  logic [75:0] a6_fmag_r;
  logic        a6_eneg_r;
  logic        a6_fneg_r;
  logic [59:0] a6_a_r;

  assign s2x   = {1'b0, a5_s2_r};
  assign twos  = 77'({a5_s_r, 1'b0});
  assign ones  = 77'(a5_s_r);
  assign eneg  = s2x < twos;
  assign fneg  = s2x < ones;
  assign ediff = eneg ? (twos - s2x) : (s2x - twos);
  assign fdiff = fneg ? (ones - s2x) : (s2x - ones);

  logic [77:0] ed;
  logic [77:0] fd;
  logic [49:0] a7_e_r [3];
  logic [55:0] a7_m_r [2][3];
  logic        a7_eneg_r;
  logic        a7_fneg_r;

  assign ed = {2'b0, a6_emag_r};
  assign fd = {2'b0, a6_fmag_r};

  logic [101:0] e_sum;
  logic [107:0] fa_sum [2];
  logic         a8_ebig_r;
  logic [49:0]  a8_em_r;
  logic [107:0] a8_fa_r [2];
  logic         a8_eneg_r;
  logic         a8_fneg_r;

  assign e_sum = 102'(a7_e_r[0]) + 102'({a7_e_r[1], 26'b0}) + {a7_e_r[2], 52'b0};
  for (genvar i = 0; i < 2; i++) begin : g_fa
    assign fa_sum[i] = 108'(a7_m_r[i][0]) + 108'({a7_m_r[i][1], 26'b0})
                     + {a7_m_r[i][2], 52'b0};
  end

  logic [137:0]       f_sum;
  logic signed [52:0] emv;
  logic signed [52:0] ev;
  logic               e_ovr;
  logic [OUT_W-1:0]   e_clamped;
  logic               e_sat;
  logic [OUT_W-1:0]   a9_e_r;
  logic               a9_esat_r;
  logic               a9_fbig_r;
  logic [49:0]        a9_fm_r;
  logic               a9_fneg_r;

  assign f_sum = 138'(a8_fa_r[0]) + {a8_fa_r[1], 30'b0};
  assign emv   = $signed({3'b0, a8_em_r});
  assign ev    = (a8_eneg_r ? -emv : emv)
               + (potential_mode_r ? 53'sd0 : $signed({29'b0, well_depth_r}));
  assign e_ovr = !((ev[52:47] == '0) || (ev[52:47] == '1));

  always_comb begin
    e_sat     = 1'b0;
    e_clamped = ev[OUT_W-1:0];
    if (a8_ebig_r) begin
      e_sat     = 1'b1;
      e_clamped = a8_eneg_r ? OUT_MIN : OUT_MAX;
    end else if (e_ovr) begin
      e_sat     = 1'b1;
      e_clamped = ev[52] ? OUT_MIN : OUT_MAX;
    end
  end

  logic               f_sign;
  logic signed [51:0] fmv;
  logic signed [51:0] fv;
  logic               f_ovr;
  logic [OUT_W-1:0]   f_clamped;
  logic               f_sat;
  logic [OUT_W-1:0]   f_rail;

  assign f_sign = a9_fneg_r ^ potential_mode_r;
  assign fmv    = $signed({2'b0, a9_fm_r});
  assign fv     = f_sign ? -fmv : fmv;
  assign f_ovr  = !((fv[51:47] == '0) || (fv[51:47] == '1));
  assign f_rail = potential_mode_r ? OUT_MIN : OUT_MAX;

  always_comb begin
    f_sat     = 1'b0;
    f_clamped = fv[OUT_W-1:0];
    if (a9_fbig_r) begin
      f_sat     = 1'b1;
      f_clamped = f_sign ? OUT_MIN : OUT_MAX;
    end else if (f_ovr) begin
      f_sat     = 1'b1;
      f_clamped = fv[51] ? OUT_MIN : OUT_MAX;
    end
  end

  logic             out_valid_r;
  logic [OUT_W-1:0] out_energy_r;
  logic [OUT_W-1:0] out_force_r;
  logic [1:0]       out_status_r;

  always_ff @(posedge clk) begin
    a1_q_r    <= q0;
    a1_q2_r   <= q_sq[41:16];
    a1_pl_r   <= epi_lo;
    a1_ph_r   <= epi_hi;

    a2_q3_r   <= q2q[46:16];
    a2_a_r    <= a_sum;

    a3_s_r    <= q3sq[61:16];
    a3_a_r    <= a2_a_r;

    a4_hh_r   <= pp_hh;
    a4_hl_r   <= pp_hl;
    a4_ll_r   <= pp_ll;
    a4_s_r    <= a3_s_r;
    a4_a_r    <= a3_a_r;

    a5_s2_r   <= s2_full[91:16];
    a5_s_r    <= a4_s_r;
    a5_a_r    <= a4_a_r;

    a6_emag_r <= ediff[75:0];
    a6_fmag_r <= fdiff[75:0];
    a6_eneg_r <= eneg;
    a6_fneg_r <= fneg;
    a6_a_r    <= a5_a_r;

    for (int j = 0; j < 3; j++) begin
      a7_e_r[j]    <= 50'(well_depth_r) * 50'(ed[26*j +: 26]);
      a7_m_r[0][j] <= 56'(a6_a_r[29:0]) * 56'(fd[26*j +: 26]);
      a7_m_r[1][j] <= 56'(a6_a_r[59:30]) * 56'(fd[26*j +: 26]);
    end
    a7_eneg_r <= a6_eneg_r;
    a7_fneg_r <= a6_fneg_r;

    a8_ebig_r  <= |e_sum[101:66];
    a8_em_r    <= e_sum[65:16];
    a8_fa_r[0] <= fa_sum[0];
    a8_fa_r[1] <= fa_sum[1];
    a8_eneg_r  <= a7_eneg_r;
    a8_fneg_r  <= a7_fneg_r;

    a9_e_r    <= e_clamped;
    a9_esat_r <= e_sat;
    a9_fbig_r <= |f_sum[137:82];
    a9_fm_r   <= f_sum[81:32];
    a9_fneg_r <= a8_fneg_r;

    if (fl_r[9].zero) begin
      out_energy_r <= OUT_MAX;
      out_force_r  <= f_rail;
      out_status_r <= ST_ZERO;
    end else if (fl_r[9].beyond) begin
      out_energy_r <= '0;
      out_force_r  <= '0;
      out_status_r <= ST_OK;
    end else if (fl_r[9].ovf) begin
      if (well_depth_r == '0) begin
        out_energy_r <= '0;
        out_force_r  <= '0;
        out_status_r <= ST_OK;
      end else begin
        out_energy_r <= OUT_MAX;
        out_force_r  <= f_rail;
        out_status_r <= ST_SAT;
      end
    end else begin
      out_energy_r <= a9_e_r;
      out_force_r  <= f_clamped;
      out_status_r <= (a9_esat_r || f_sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= av_r[9];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_energy    = out_energy_r;
  assign out_force_res = out_force_r;
  assign out_status    = out_status_r;

  `LJ_ASSERT(a_rst_drops, !rst_n |=> !out_valid, "result strobe after reset")
  `LJ_ASSERT_RST(a_zero_rail,
                 out_valid && out_status == ST_ZERO |-> out_energy == OUT_MAX,
                 "zero distance energy not at rail")
  `LJ_ASSERT_RST(a_sat_rail,
                 out_valid && out_status == ST_SAT |-> out_energy == OUT_MAX ||
                 out_energy == OUT_MIN || out_force_res == OUT_MAX ||
                 out_force_res == OUT_MIN,
                 "saturated status without a clamped field")

endmodule

>>> bench/tb_lennard_jones_wca_pair_evaluator_unit.sv
`timescale 1ns / 1ps
module tb_lennard_jones_wca_pair_evaluator_unit;
  import ljwca_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] energy;
    logic signed [OUT_W-1:0] force_res;
    status_t                 status;
  } pair_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [DIST_W-1:0]       in_distance;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [DIST_W-1:0]       cfg_wdata;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_energy;
  logic signed [OUT_W-1:0] out_force_res;
  logic [1:0]              out_status;

  logic [DIST_W-1:0] eps_q;
  logic [DIST_W-1:0] rmin_q;
  logic              full_mode;

  logic [DIST_W-1:0] pending_dist[$];
  pair_result_t      expected_pairs[$];
  int                gap_left;
  bit                no_gaps;
  bit                taken;
  int                errors;
  int                quiet_cycles;

  localparam int QUIET_LIMIT = 5000;

  lennard_jones_wca_pair_evaluator_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_distance  (in_distance),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_energy   (out_energy),
    .out_force_res(out_force_res),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_out(input longint v, inout logic sat);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
      sat = 1'b1;
      return 64'sh0000_7FFF_FFFF_FFFF;
    end
    if (v < -64'sh0000_8000_0000_0000) begin
      sat = 1'b1;
      return -64'sh0000_8000_0000_0000;
    end
    return v;
  endfunction

  function automatic pair_result_t eval_pair(input logic [DIST_W-1:0] r);
    pair_result_t res;
    logic [63:0]  q, q2, q3, s, inv, a;
    logic [191:0] s2, two_s, dmag_e, dmag_f, prod, cap;
    logic         eneg, fneg, sat;
    longint       e, f;
    cap = 192'd1 << 62;
    sat = 1'b0;
    if (r == 0) begin
      res.energy = OUT_MAX;
      res.force_res = full_mode ? OUT_MIN : OUT_MAX;
      res.status = ST_ZERO;
      return res;
    end
    if (!full_mode && r >= rmin_q) begin
      res.energy = '0;
      res.force_res = '0;
      res.status = ST_OK;
      return res;
    end
    q = ({40'd0, rmin_q} << 16) / {40'd0, r};
    if (q >= (64'd1 << 21)) begin
      if (eps_q == 0) begin
        res.energy = '0;
        res.force_res = '0;
        res.status = ST_OK;
      end else begin
        res.energy = OUT_MAX;
        res.force_res = full_mode ? OUT_MIN : OUT_MAX;
        res.status = ST_SAT;
      end
      return res;
    end
    q2 = (q * q) >> 16;
    q3 = (q2 * q) >> 16;
    s = (q3 * q3) >> 16;
    s2 = ({128'd0, s} * {128'd0, s}) >> 16;
    two_s = {128'd0, s} << 1;
    eneg = s2 < two_s;
    dmag_e = eneg ? two_s - s2 : s2 - two_s;
    fneg = s2 < {128'd0, s};
    dmag_f = fneg ? {128'd0, s} - s2 : s2 - {128'd0, s};
    prod = ({168'd0, eps_q} * dmag_e) >> 16;
    if (prod > cap) prod = cap;
    e = eneg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    if (!full_mode) e += longint'({40'd0, eps_q});
    inv = (64'd12 << 32) / {40'd0, r};
    a = {40'd0, eps_q} * inv;
    prod = ({128'd0, a} * dmag_f) >> 32;
    if (prod > cap) prod = cap;
    f = fneg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    if (full_mode) f = -f;
    e = clamp_out(e, sat);
    f = clamp_out(f, sat);
    res.energy = e[OUT_W-1:0];
    res.force_res = f[OUT_W-1:0];
    res.status = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_WELL_DEPTH: eps_q = val;
      CFG_MIN_DISTANCE: rmin_q = val;
      CFG_POTENTIAL_MODE: full_mode = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_dist.size() == 0 && expected_pairs.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [DIST_W-1:0] pick_distance();
    int sel;
    logic [DIST_W-1:0] d;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      d = DIST_W'($urandom_range(rmin_q / 2, rmin_q + rmin_q / 4 + 1));
    end else if (sel < 7) begin
      d = DIST_W'($urandom_range(rmin_q / 40 + 1, rmin_q + 2));
    end else if (sel < 9) begin
      d = DIST_W'($urandom);
    end else begin
      d = DIST_W'($urandom_range(0, 3));
    end
    return d;
  endfunction

  task automatic random_phase(input int count);
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (count) pending_dist.push_back(pick_distance());
    drain();
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_dist.size() > 0) begin
      start <= 1'b1;
      in_distance <= pending_dist.pop_front();
      if (no_gaps || $urandom_range(0, 9) < 6) gap_left <= 0;
      else if ($urandom_range(0, 9) < 9) gap_left <= $urandom_range(1, 3);
      else gap_left <= $urandom_range(10, 40);
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pair_result_t exp_r;
    taken = rst_n && start && !busy;
    if (rst_n) begin
      if (taken) expected_pairs.push_back(eval_pair(in_distance));
      if (out_valid) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t unexpected transaction: energy %0d force %0d status %0d",
                   $time, out_energy, out_force_res, out_status);
          errors++;
        end else begin
          exp_r = expected_pairs.pop_front();
          if (out_energy !== exp_r.energy) begin
            $display("%0t energy: expected %0d actual %0d", $time, exp_r.energy, out_energy);
            errors++;
          end
          if (out_force_res !== exp_r.force_res) begin
            $display("%0t force_res: expected %0d actual %0d", $time, exp_r.force_res,
                     out_force_res);
            errors++;
          end
          if (out_status !== exp_r.status) begin
            $display("%0t status: expected %0d actual %0d", $time, exp_r.status, out_status);
            errors++;
          end
        end
      end
      if (taken || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("lennard_jones_wca_pair_evaluator_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_distance = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WELL_DEPTH;
    cfg_wdata = '0;
    errors = 0;
    quiet_cycles = 0;
    taken = 1'b0;
    no_gaps = 1'b0;
    eps_q = WELL_DEPTH_RST;
    rmin_q = MIN_DISTANCE_RST;
    full_mode = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    pending_dist = '{24'd0, 24'd1, 24'hFFFFFF, 24'h010000, 24'h00FFFF, 24'h010001,
                     24'h000800, 24'h000801, 24'h00E000, 24'h00C000};
    drain();
    write_reg(CFG_POTENTIAL_MODE, 24'd1);
    pending_dist = '{24'd0, 24'd1, 24'hFFFFFF, 24'h010000, 24'h00FFFF, 24'h020000,
                     24'h00E3A0, 24'h000801};
    drain();
    write_reg(CFG_WELL_DEPTH, 24'd0);
    pending_dist = '{24'd1, 24'h008000, 24'd0};
    drain();
    write_reg(CFG_WELL_DEPTH, 24'hFFFFFF);
    write_reg(CFG_MIN_DISTANCE, 24'hFFFFFF);
    pending_dist = '{24'hFFFFFF, 24'h7FFFFF, 24'h080000};
    drain();

    random_phase(90);
    write_reg(CFG_POTENTIAL_MODE, 24'd0);
    random_phase(90);
    write_reg(CFG_MIN_DISTANCE, 24'd1);
    random_phase(40);
    write_reg(CFG_WELL_DEPTH, WELL_DEPTH_RST);
    write_reg(CFG_MIN_DISTANCE, MIN_DISTANCE_RST);
    random_phase(90);
    write_reg(CFG_POTENTIAL_MODE, 24'd1);
    random_phase(90);
    repeat (6) begin
      write_reg(CFG_WELL_DEPTH, DIST_W'($urandom));
      write_reg(CFG_MIN_DISTANCE, DIST_W'($urandom_range(1, 24'hFFFFFF)));
      write_reg(CFG_POTENTIAL_MODE, DIST_W'($urandom_range(0, 1)));
      random_phase(60);
    end

    if (errors == 0) begin
      $display("lennard_jones_wca_pair_evaluator_unit: match");
    end else begin
      $display("lennard_jones_wca_pair_evaluator_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> lennard_jones_wca_pair_evaluator_unit.f
+incdir+rtl/core
rtl/core/ljwca_pkg.sv
rtl/core/ljwca_div.sv
rtl/core/lennard_jones_wca_pair_evaluator_unit.sv
bench/tb_lennard_jones_wca_pair_evaluator_unit.sv
